// File: rtl/swre_pkg.sv
// Package: shared widths, event codes, register indexes and reset values.
package swre_pkg;

   // Field widths
   localparam int WIN_BITS       = 8;
   localparam int RTT_BITS       = 16;
   localparam int FUNC_BITS      = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // Default internal time width
   localparam int TIME_BITS_DEFAULT = 16;

   // Event codes
   localparam logic [FUNC_BITS-1:0] FUNC_SEND  = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_ACK   = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_RETRY = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOW_START_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_WINDOW       = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_TIMEOUT_MS   = 2'd2;

   // Register and state reset values
   localparam logic [WIN_BITS-1:0] SLOW_START_RESET  = 8'd16;
   localparam logic [WIN_BITS-1:0] MAX_WINDOW_RESET  = 8'd64;
   localparam logic [RTT_BITS-1:0] MAX_TIMEOUT_RESET = 16'd1000;
   localparam logic [WIN_BITS-1:0] WINDOW_RESET      = 8'd1;

   // Lower clamp on the retransmission timeout, in ms
   localparam int MIN_TIMEOUT_MS = 100;

endpackage

// File: rtl/send_window_rtt_estimator_top.sv
// Top level: send window control and smoothed RTT / retransmission timeout.
//
// Takes one event per cycle while req_stall is low (send request,
// acknowledgement with a measured RTT, or retry) and returns one result
// per event. An event is held in an input register. While it is held, one
// pass of logic updates the window, the in-flight count, the smoothed RTT,
// the mean deviation and the timeout, and loads the result register once
// the result slot is free. The sustained rate is one event per clock while
// no result is stalled. The state feedback (RTT average -> deviation ->
// timeout) closes within that single pass. A stalled result holds the
// input register; req_stall then rises only while both stages are full.
// Configuration writes are always ready and apply to the next event; a new
// max_timeout_ms takes effect at the next acknowledgement. Times inside
// are TIME_BITS wide and saturate.
module send_window_rtt_estimator_top #(
   parameter int TIME_BITS = swre_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [swre_pkg::FUNC_BITS-1:0]      req_func,
   input  logic [swre_pkg::RTT_BITS-1:0]       req_rtt_ms,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_granted,
   output logic [swre_pkg::WIN_BITS-1:0]       rsp_window_now,
   output logic [swre_pkg::WIN_BITS-1:0]       rsp_outstanding,
   output logic [swre_pkg::RTT_BITS-1:0]       rsp_timeout_now_ms,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [swre_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [swre_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import swre_pkg::*;

   // Arithmetic width: covers 8x the largest time and the 16-bit port values
   localparam int CALC_BITS = ((TIME_BITS > RTT_BITS) ? TIME_BITS : RTT_BITS) + 3;
   localparam logic [CALC_BITS-1:0] TIME_MAX_W =
      (CALC_BITS'(1) << TIME_BITS) - CALC_BITS'(1);
   localparam logic [CALC_BITS-1:0] MIN_TIMEOUT_W = CALC_BITS'(MIN_TIMEOUT_MS);
   localparam logic [CALC_BITS-1:0] TIMEOUT_RESET_W =
      (CALC_BITS'(MAX_TIMEOUT_RESET) > TIME_MAX_W) ? TIME_MAX_W
                                                    : CALC_BITS'(MAX_TIMEOUT_RESET);
   localparam logic [TIME_BITS-1:0] TIMEOUT_RESET = TIME_BITS'(TIMEOUT_RESET_W);

   // Configuration registers
   logic [WIN_BITS-1:0] slow_start_ff;
   logic [WIN_BITS-1:0] max_window_ff;
   logic [RTT_BITS-1:0] max_timeout_ff;

   // Input stage
   logic                 in_valid_ff;
   logic [FUNC_BITS-1:0] in_func_ff;
   logic [RTT_BITS-1:0]  in_rtt_ff;

   // Flow state
   logic [WIN_BITS-1:0]  window_ff,   window_in;
   logic [WIN_BITS-1:0]  in_flight_ff, in_flight_in;
   logic [TIME_BITS-1:0] avg_ff,      avg_in;
   logic [TIME_BITS-1:0] dev_ff,      dev_in;
   logic [TIME_BITS-1:0] timeout_ff,  timeout_in;
   logic                 granted_in;

   // Result stage
   logic                 out_valid_ff;
   logic                 out_granted_ff;
   logic [WIN_BITS-1:0]  out_window_ff;
   logic [WIN_BITS-1:0]  out_in_flight_ff;
   logic [RTT_BITS-1:0]  out_timeout_ff;

   // Handshake
   logic advance;
   logic req_take;

   // Acknowledgement datapath
   logic [WIN_BITS:0]    win_double;
   logic [WIN_BITS-1:0]  win_grown;
   logic [CALC_BITS-1:0] rtt_w, rtt_sat;
   logic [CALC_BITS-1:0] avg_w, avg_sum, avg_new_w;
   logic [CALC_BITS-1:0] diff_w;
   logic [CALC_BITS-1:0] dev_w, dev_sum, dev_new_w;
   logic [CALC_BITS-1:0] to_sum, to_low, to_high, to_sat;
   logic [CALC_BITS-1:0] max_to_w;

   // Stage handshake: the input stage moves on when the result slot frees up
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Window growth on acknowledgement
   always_comb begin
      win_double = {window_ff, 1'b0};
      if (window_ff < slow_start_ff) begin
         win_grown = (win_double < {1'b0, slow_start_ff}) ? win_double[WIN_BITS-1:0]
                                                          : slow_start_ff;
      end else if (window_ff < max_window_ff) begin
         win_grown = window_ff + WIN_BITS'(1);
      end else begin
         win_grown = window_ff;
      end
   end

   // RTT average, deviation and timeout
   always_comb begin
      rtt_w     = CALC_BITS'(in_rtt_ff);
      rtt_sat   = (rtt_w > TIME_MAX_W) ? TIME_MAX_W : rtt_w;
      avg_w     = CALC_BITS'(avg_ff);
      avg_sum   = (avg_w << 3) - avg_w + rtt_sat;
      avg_new_w = avg_sum >> 3;
      diff_w    = (avg_new_w > rtt_sat) ? (avg_new_w - rtt_sat) : (rtt_sat - avg_new_w);
      dev_w     = CALC_BITS'(dev_ff);
      dev_sum   = (dev_w << 1) + dev_w + diff_w;
      dev_new_w = dev_sum >> 2;
      to_sum    = avg_new_w + (dev_new_w << 2);
      max_to_w  = CALC_BITS'(max_timeout_ff);
      to_low    = (to_sum < MIN_TIMEOUT_W) ? MIN_TIMEOUT_W : to_sum;
      to_high   = (to_low > max_to_w) ? max_to_w : to_low;
      to_sat    = (to_high > TIME_MAX_W) ? TIME_MAX_W : to_high;
   end

   // Event decode and next state
   always_comb begin
      window_in    = window_ff;
      in_flight_in = in_flight_ff;
      avg_in       = avg_ff;
      dev_in       = dev_ff;
      timeout_in   = timeout_ff;
      granted_in   = 1'b0;
      case (in_func_ff)
         FUNC_SEND: begin
            if (in_flight_ff < window_ff) begin
               in_flight_in = in_flight_ff + WIN_BITS'(1);
               granted_in   = 1'b1;
            end
         end
         FUNC_ACK: begin
            if (in_flight_ff != '0) begin
               in_flight_in = in_flight_ff - WIN_BITS'(1);
               window_in    = win_grown;
               avg_in       = TIME_BITS'(avg_new_w);
               dev_in       = TIME_BITS'(dev_new_w);
               timeout_in   = TIME_BITS'(to_sat);
            end
         end
         FUNC_RETRY: begin
            window_in = (window_ff > WIN_BITS'(1)) ? (window_ff >> 1) : WINDOW_RESET;
         end
         default: begin
         end
      endcase
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slow_start_ff  <= SLOW_START_RESET;
         max_window_ff  <= MAX_WINDOW_RESET;
         max_timeout_ff <= MAX_TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SLOW_START_LIMIT: slow_start_ff  <= csr_data[WIN_BITS-1:0];
            CSR_MAX_WINDOW:       max_window_ff  <= csr_data[WIN_BITS-1:0];
            CSR_MAX_TIMEOUT_MS:   max_timeout_ff <= csr_data[RTT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input stage: valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   // Input stage: payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff <= req_func;
         in_rtt_ff  <= req_rtt_ms;
      end
   end

   // Flow state update
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         in_flight_ff <= '0;
         avg_ff       <= '0;
         dev_ff       <= '0;
         timeout_ff   <= TIMEOUT_RESET;
      end else if (advance) begin
         window_ff    <= window_in;
         in_flight_ff <= in_flight_in;
         avg_ff       <= avg_in;
         dev_ff       <= dev_in;
         timeout_ff   <= timeout_in;
      end
   end

   // Result stage: valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Result stage: payload
   always_ff @(posedge clock) begin
      if (advance) begin
         out_granted_ff   <= granted_in;
         out_window_ff    <= window_in;
         out_in_flight_ff <= in_flight_in;
         out_timeout_ff   <= RTT_BITS'(timeout_in);
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_granted        = out_granted_ff;
   assign rsp_window_now     = out_window_ff;
   assign rsp_outstanding    = out_in_flight_ff;
   assign rsp_timeout_now_ms = out_timeout_ff;

endmodule

// File: rtl/swre_checker.sv
// Checker: port-level assertions for the send window estimator, with bind.
module swre_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_granted,
   input logic [swre_pkg::WIN_BITS-1:0]       rsp_window_now,
   input logic [swre_pkg::WIN_BITS-1:0]       rsp_outstanding,
   input logic [swre_pkg::RTT_BITS-1:0]       rsp_timeout_now_ms
);
   import swre_pkg::*;

   // A stalled result keeps its valid and payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_granted)
         && $stable(rsp_window_now) && $stable(rsp_outstanding)
         && $stable(rsp_timeout_now_ms))
      else $error("result changed while stalled");

   // No result is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A grant leaves at least one packet in flight and stays within the window
   a_grant_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> (rsp_outstanding != '0)
         && (rsp_outstanding <= rsp_window_now))
      else $error("grant outside the window");

   // The window never drops to zero
   a_window_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_window_now != '0)
      else $error("window size is zero");

endmodule

bind send_window_rtt_estimator_top swre_checker u_swre_checker (.*);

// File: bench/tb_send_window_rtt_estimator_top.sv
// Testbench for send_window_rtt_estimator_top: random and directed flow events checked against a predictor.
module tb_send_window_rtt_estimator_top;
   timeunit 1ns;
   timeprecision 1ps;

   import swre_pkg::*;

   // Event code with no meaning and register index past the list
   localparam logic [FUNC_BITS-1:0]      FUNC_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE   = 2'd3;

   typedef struct {
      logic [FUNC_BITS-1:0] func;
      logic [RTT_BITS-1:0]  rtt_ms;
   } flow_event_type;

   typedef struct {
      logic                granted;
      logic [WIN_BITS-1:0] window_now;
      logic [WIN_BITS-1:0] outstanding;
      logic [RTT_BITS-1:0] timeout_now_ms;
   } flow_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [FUNC_BITS-1:0]      req_func = '0;
   logic [RTT_BITS-1:0]       req_rtt_ms = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_granted;
   logic [WIN_BITS-1:0]       rsp_window_now;
   logic [WIN_BITS-1:0]       rsp_outstanding;
   logic [RTT_BITS-1:0]       rsp_timeout_now_ms;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   send_window_rtt_estimator_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_rtt_ms         (req_rtt_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_granted        (rsp_granted),
      .rsp_window_now     (rsp_window_now),
      .rsp_outstanding    (rsp_outstanding),
      .rsp_timeout_now_ms (rsp_timeout_now_ms),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   flow_event_type  pending_events[$];
   flow_result_type predicted_results[$];
   int              error_count = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;

   // Predicted flow state and limits
   logic [WIN_BITS-1:0] cfg_ssthresh;
   logic [WIN_BITS-1:0] cfg_max_win;
   logic [RTT_BITS-1:0] cfg_max_rto;
   logic [WIN_BITS-1:0] win_size;
   logic [WIN_BITS-1:0] pkts_in_flight;
   logic [RTT_BITS-1:0] srtt;
   logic [RTT_BITS-1:0] rtt_var;
   logic [RTT_BITS-1:0] rto_ms;

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop
   initial begin
      #5_000_000;
      $display("send_window_rtt_estimator_top test failed");
      $finish;
   end

   function automatic void reset_flow();
      cfg_ssthresh   = SLOW_START_RESET;
      cfg_max_win    = MAX_WINDOW_RESET;
      cfg_max_rto    = MAX_TIMEOUT_RESET;
      win_size       = WINDOW_RESET;
      pkts_in_flight = '0;
      srtt           = '0;
      rtt_var        = '0;
      rto_ms         = MAX_TIMEOUT_RESET;
   endfunction

   // Apply one event to the predicted flow state and return the result it yields
   function automatic flow_result_type advance_flow(logic [FUNC_BITS-1:0] fn,
                                                    logic [RTT_BITS-1:0] rtt);
      flow_result_type res;
      int unsigned     doubled;
      int unsigned     spread;
      int unsigned     rto;
      res.granted = 1'b0;
      case (fn)
         FUNC_SEND: begin
            if (pkts_in_flight < win_size) begin
               pkts_in_flight = pkts_in_flight + 1'b1;
               res.granted = 1'b1;
            end
         end
         FUNC_ACK: begin
            // ack with nothing outstanding is a no-op
            if (pkts_in_flight != 0) begin
               pkts_in_flight = pkts_in_flight - 1'b1;
               if (win_size < cfg_ssthresh) begin
                  doubled  = 32'(win_size) * 2;
                  win_size = (doubled < cfg_ssthresh) ? doubled[WIN_BITS-1:0] : cfg_ssthresh;
               end else if (win_size < cfg_max_win) begin
                  win_size = win_size + 1'b1;
               end
               srtt    = RTT_BITS'((32'd7 * srtt + 32'(rtt)) / 32'd8);
               spread  = (srtt > rtt) ? 32'(srtt) - 32'(rtt) : 32'(rtt) - 32'(srtt);
               rtt_var = RTT_BITS'((32'd3 * rtt_var + spread) / 32'd4);
               rto     = 32'(srtt) + 32'd4 * rtt_var;
               if (rto < MIN_TIMEOUT_MS)
                  rto = MIN_TIMEOUT_MS;
               if (rto > 32'(cfg_max_rto))
                  rto = 32'(cfg_max_rto);
               rto_ms = rto[RTT_BITS-1:0];
            end
         end
         FUNC_RETRY: begin
            win_size = win_size >> 1;
            if (win_size == 0)
               win_size = WINDOW_RESET;
         end
         default: ;
      endcase
      res.window_now     = win_size;
      res.outstanding    = pkts_in_flight;
      res.timeout_now_ms = rto_ms;
      return res;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Request driver: predicts each transfer as it is taken, then offers the next event
   always @(posedge clock) begin
      flow_event_type ev;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predicted_results.insert(predicted_results.size(),
                                     advance_flow(req_func, req_rtt_ms));
         if (req_valid && req_stall) begin
            // hold the stalled transfer
         end else if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            ev = pending_events.pop_front();
            req_valid  <= 1'b1;
            req_func   <= ev.func;
            req_rtt_ms <= ev.rtt_ms;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor and random back-pressure
   always @(posedge clock) begin
      flow_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_results.size() == 0) begin
               $display("%0t: result transfer with none expected, actual granted %0d window %0d",
                        $time, rsp_granted, rsp_window_now);
               error_count++;
            end else begin
               want = predicted_results.pop_front();
               check_field("granted", 32'(want.granted), 32'(rsp_granted));
               check_field("window_now", 32'(want.window_now), 32'(rsp_window_now));
               check_field("outstanding", 32'(want.outstanding), 32'(rsp_outstanding));
               check_field("timeout_now_ms", 32'(want.timeout_now_ms),
                           32'(rsp_timeout_now_ms));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic queue_event(logic [FUNC_BITS-1:0] fn, logic [RTT_BITS-1:0] rtt);
      flow_event_type ev;
      ev.func   = fn;
      ev.rtt_ms = rtt;
      pending_events.insert(pending_events.size(), ev);
   endtask

   // Mostly plausible RTTs, with extremes and full-range values mixed in
   function automatic logic [RTT_BITS-1:0] random_rtt();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return RTT_BITS'($urandom_range(65535));
         default: return RTT_BITS'($urandom_range(20, 600));
      endcase
   endfunction

   // Send bursts followed by ack runs, with retries and noise sprinkled in
   task automatic queue_random_traffic(int count);
      int n;
      int burst;
      int acks;
      int pick;
      n = 0;
      while (n < count) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            burst = ($urandom_range(9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 24);
            acks  = $urandom_range(1, burst + 2);
            repeat (burst)
               queue_event(FUNC_SEND, random_rtt());
            repeat (acks) begin
               if ($urandom_range(19) == 0)
                  queue_event(FUNC_RETRY, random_rtt());
               queue_event(FUNC_ACK, random_rtt());
            end
            n += burst + acks;
         end else if (pick < 88) begin
            queue_event(FUNC_BITS'($urandom_range(3)), RTT_BITS'($urandom_range(65535)));
            n++;
         end else begin
            queue_event(FUNC_RETRY, RTT_BITS'($urandom_range(65535)));
            n++;
         end
      end
   endtask

   // Wait until every queued event has been taken and every result seen
   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_events.size() != 0 || req_valid || predicted_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Register write; the predictor takes it when the transfer happens
   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SLOW_START_LIMIT: cfg_ssthresh = data[WIN_BITS-1:0];
         CSR_MAX_WINDOW:       cfg_max_win  = data[WIN_BITS-1:0];
         CSR_MAX_TIMEOUT_MS:   cfg_max_rto  = data;
         default: ;
      endcase
   endtask

   task automatic program_limits(logic [WIN_BITS-1:0] ssthresh, logic [WIN_BITS-1:0] max_win,
                                 logic [RTT_BITS-1:0] max_rto);
      // upper byte of the 8-bit registers carries junk that must be dropped
      write_csr(CSR_SLOW_START_LIMIT, {8'($urandom), ssthresh});
      write_csr(CSR_MAX_WINDOW, {8'($urandom), max_win});
      write_csr(CSR_MAX_TIMEOUT_MS, max_rto);
   endtask

   // Stimulus sequence
   initial begin
      reset_flow();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset limits, empty-window and clamp corners
      send_idle_pct = 37;
      recv_idle_pct = 37;
      queue_event(FUNC_ACK, 16'hFFFF);      // ack with nothing outstanding
      queue_event(FUNC_RETRY, 16'h0000);    // halving at window 1 stays at 1
      queue_event(FUNC_UNUSED, 16'hFFFF);   // unused event code
      queue_event(FUNC_SEND, 16'h0000);     // granted
      queue_event(FUNC_SEND, 16'h0000);     // window full, denied
      queue_event(FUNC_ACK, 16'h0000);      // timeout floors at 100
      queue_event(FUNC_SEND, 16'h1234);
      queue_event(FUNC_SEND, 16'h0000);
      queue_event(FUNC_ACK, 16'hFFFF);      // timeout clamped to max
      queue_event(FUNC_ACK, 16'hFFFF);
      repeat (4) queue_event(FUNC_SEND, 16'h00FF);
      queue_event(FUNC_RETRY, 16'h0000);
      queue_event(FUNC_RETRY, 16'h0000);    // in flight now above window
      queue_event(FUNC_SEND, 16'h0000);     // denied until acks catch up
      repeat (3) queue_event(FUNC_ACK, 16'd300);
      queue_event(FUNC_SEND, 16'd300);
      queue_event(FUNC_UNUSED, 16'h0000);
      queue_random_traffic(200);
      wait_drained();

      // Widest limits, with a full drain midway
      program_limits(8'd255, 8'd255, 16'hFFFF);
      queue_random_traffic(150);
      wait_drained();
      queue_random_traffic(150);
      wait_drained();

      // Zero limits: no growth, timeout pinned at zero; spare index ignored
      program_limits(8'd0, 8'd0, 16'd0);
      write_csr(CSR_SPARE, 16'hFFFF);
      queue_random_traffic(200);
      wait_drained();

      // Tiny limits, timeout clamp below the floor, no idling at all
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_limits(8'd1, 8'd255, 16'd99);
      queue_random_traffic(150);
      wait_drained();

      // Random limits
      send_idle_pct = 37;
      recv_idle_pct = 37;
      repeat (3) begin
         program_limits(WIN_BITS'($urandom_range(1, 255)), WIN_BITS'($urandom_range(1, 255)),
                        RTT_BITS'($urandom_range(100, 65535)));
         queue_random_traffic(180);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("send_window_rtt_estimator_top test passed");
      else
         $display("send_window_rtt_estimator_top test failed");
      $finish;
   end

endmodule
